>>> hw/rtl/h2ps2_pkg.sv
// ----------------------------------------------------------------------------
// h2ps2_pkg
// shared constants, code table and sequence helpers for the hid to ps/2
// scancode emitter
// ----------------------------------------------------------------------------
package h2ps2_pkg;

    localparam logic [7:0] BYTE_EXT   = 8'hE0;
    localparam logic [7:0] BYTE_BREAK = 8'hF0;
    localparam logic [7:0] BYTE_E1    = 8'hE1;
    localparam logic [7:0] BYTE_12    = 8'h12;
    localparam logic [7:0] BYTE_7C    = 8'h7C;
    localparam logic [7:0] BYTE_14    = 8'h14;
    localparam logic [7:0] BYTE_77    = 8'h77;
    localparam logic [7:0] BYTE_FF    = 8'hFF;

    localparam logic KIND_MAKE  = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

    // table entry: [9:8] class, [7:0] set 2 code
    typedef logic [9:0] t_code;
    typedef logic [3:0] t_len;
    typedef logic [2:0] t_idx;

    localparam logic [1:0] CLS_PLAIN = 2'd0;
    localparam logic [1:0] CLS_EXT   = 2'd1;
    localparam logic [1:0] CLS_PRINT = 2'd2;
    localparam logic [1:0] CLS_PAUSE = 2'd3;

    localparam t_code CODE_NONE  = 10'h000;
    localparam t_code CODE_PRINT = {CLS_PRINT, 8'h00};
    localparam t_code CODE_PAUSE = {CLS_PAUSE, 8'h00};

    function automatic t_code set2_of_usage(input logic [7:0] usage);
        t_code c;
        c = CODE_NONE;
        case (usage)
            8'h04: c = 10'h01C; 8'h05: c = 10'h032; 8'h06: c = 10'h021; 8'h07: c = 10'h023;
            8'h08: c = 10'h024; 8'h09: c = 10'h02B; 8'h0A: c = 10'h034; 8'h0B: c = 10'h033;
            8'h0C: c = 10'h043; 8'h0D: c = 10'h03B; 8'h0E: c = 10'h042; 8'h0F: c = 10'h04B;
            8'h10: c = 10'h03A; 8'h11: c = 10'h031; 8'h12: c = 10'h044; 8'h13: c = 10'h04D;
            8'h14: c = 10'h015; 8'h15: c = 10'h02D; 8'h16: c = 10'h01B; 8'h17: c = 10'h02C;
            8'h18: c = 10'h03C; 8'h19: c = 10'h02A; 8'h1A: c = 10'h01D; 8'h1B: c = 10'h022;
            8'h1C: c = 10'h035; 8'h1D: c = 10'h01A;
            8'h1E: c = 10'h016; 8'h1F: c = 10'h01E; 8'h20: c = 10'h026; 8'h21: c = 10'h025;
            8'h22: c = 10'h02E; 8'h23: c = 10'h036; 8'h24: c = 10'h03D; 8'h25: c = 10'h03E;
            8'h26: c = 10'h046; 8'h27: c = 10'h045;
            8'h28: c = 10'h05A; 8'h29: c = 10'h076; 8'h2A: c = 10'h066; 8'h2B: c = 10'h00D;
            8'h2C: c = 10'h029; 8'h39: c = 10'h058;
            8'h2D: c = 10'h04E; 8'h2E: c = 10'h055; 8'h2F: c = 10'h054; 8'h30: c = 10'h05B;
            8'h31: c = 10'h05D; 8'h33: c = 10'h04C; 8'h34: c = 10'h052; 8'h35: c = 10'h00E;
            8'h36: c = 10'h041; 8'h37: c = 10'h049; 8'h38: c = 10'h04A;
            8'h64: c = 10'h061;
            8'h3A: c = 10'h005; 8'h3B: c = 10'h006; 8'h3C: c = 10'h004; 8'h3D: c = 10'h00C;
            8'h3E: c = 10'h003; 8'h3F: c = 10'h00B; 8'h40: c = 10'h083; 8'h41: c = 10'h00A;
            8'h42: c = 10'h001; 8'h43: c = 10'h009; 8'h44: c = 10'h078; 8'h45: c = 10'h007;
            8'h46: c = CODE_PRINT; 8'h47: c = 10'h07E; 8'h48: c = CODE_PAUSE;
            8'h49: c = {CLS_EXT, 8'h70}; 8'h4A: c = {CLS_EXT, 8'h6C};
            8'h4B: c = {CLS_EXT, 8'h7D}; 8'h4C: c = {CLS_EXT, 8'h71};
            8'h4D: c = {CLS_EXT, 8'h69}; 8'h4E: c = {CLS_EXT, 8'h7A};
            8'h4F: c = {CLS_EXT, 8'h74}; 8'h50: c = {CLS_EXT, 8'h6B};
            8'h51: c = {CLS_EXT, 8'h72}; 8'h52: c = {CLS_EXT, 8'h75};
            8'h53: c = 10'h077; 8'h54: c = {CLS_EXT, 8'h4A}; 8'h55: c = 10'h07C;
            8'h56: c = 10'h07B; 8'h57: c = 10'h079; 8'h58: c = {CLS_EXT, 8'h5A};
            8'h59: c = 10'h069; 8'h5A: c = 10'h072; 8'h5B: c = 10'h07A; 8'h5C: c = 10'h06B;
            8'h5D: c = 10'h073; 8'h5E: c = 10'h074; 8'h5F: c = 10'h06C; 8'h60: c = 10'h075;
            8'h61: c = 10'h07D; 8'h62: c = 10'h070; 8'h63: c = 10'h071;
            8'h65: c = {CLS_EXT, 8'h2F};
            default: c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic t_len seq_len(input logic kind, input t_code code);
        t_len n;
        n = 4'd0;
        if (code == CODE_NONE) begin
            n = 4'd0;
        end else begin
            case (code[9:8])
                CLS_PRINT: n = (kind == KIND_BREAK) ? 4'd6 : 4'd4;
                CLS_PAUSE: n = (kind == KIND_BREAK) ? 4'd0 : 4'd8;
                CLS_EXT:   n = (kind == KIND_BREAK) ? 4'd3 : 4'd2;
                default:   n = (kind == KIND_BREAK) ? 4'd2 : 4'd1;
            endcase
        end
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input logic kind, input t_code code,
                                            input t_idx idx);
        logic [7:0] b;
        t_idx       p;
        b = code[7:0];
        p = idx;
        case (code[9:8])
            CLS_PRINT: begin
                if (kind == KIND_BREAK) begin
                    case (idx)
                        3'd0: b = BYTE_EXT;   3'd1: b = BYTE_BREAK; 3'd2: b = BYTE_7C;
                        3'd3: b = BYTE_EXT;   3'd4: b = BYTE_BREAK; default: b = BYTE_12;
                    endcase
                end else begin
                    case (idx)
                        3'd0: b = BYTE_EXT; 3'd1: b = BYTE_12;
                        3'd2: b = BYTE_EXT; default: b = BYTE_7C;
                    endcase
                end
            end
            CLS_PAUSE: begin
                case (idx)
                    3'd0: b = BYTE_E1;    3'd1: b = BYTE_14;    3'd2: b = BYTE_77;
                    3'd3: b = BYTE_E1;    3'd4: b = BYTE_BREAK; 3'd5: b = BYTE_14;
                    3'd6: b = BYTE_BREAK; default: b = BYTE_77;
                endcase
            end
            default: begin
                // position in the full e0, f0, code frame
                if (code[9:8] != CLS_EXT) p = p + 3'd1;
                if (kind != KIND_BREAK && p != 3'd0) p = p + 3'd1;
                case (p)
                    3'd0:    b = BYTE_EXT;
                    3'd1:    b = BYTE_BREAK;
                    default: b = code[7:0];
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/hid_to_ps2_scancode_emitter.sv
// ----------------------------------------------------------------------------
// hid_to_ps2_scancode_emitter
// turns usb hid key events into ps/2 scan code set 2 byte sequences
// ----------------------------------------------------------------------------
// input beats: s_axis, tdata = hid_usage[7:0], tuser = kind (0 make, 1 break).
// output beats: m_axis, tdata = scan_byte[7:0], tlast marks the final byte
// of one key event's sequence; events without a set 2 code, and pause
// breaks, give no beat. the usage is looked up in a code rom with a
// registered read; the looked-up entry then drives a byte sequencer that
// walks the event's one to eight bytes, one byte per cycle while the
// receiver does not stall, into an output register; an event passes the
// rom stage and the sequencer, and its bytes the output register, on the
// way to m_axis. the sequencer holds an event until its last byte goes out,
// and an event with no bytes leaves the rom stage without entering it;
// input beats are taken while the previous event is still being sent, so the output can stream without gaps.
// a stalled receiver holds the output register, then the sequencer, then
// the rom stage, and finally deasserts s_axis_tready.
// reset clears all valid flags; nothing is pending after reset.
// ----------------------------------------------------------------------------
module hid_to_ps2_scancode_emitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // hid_usage[7:0]
    input  logic       s_axis_tuser,   // kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // scan_byte[7:0]
    output logic       m_axis_tlast
);

    // rom read stage
    logic                   r_s1_vld;
    logic                   r_s1_kind;
    h2ps2_pkg::t_code       r_s1_code;
    h2ps2_pkg::t_len        s1_len;

    // sequencer stage
    logic                   r_s2_vld, n_s2_vld;
    logic                   r_s2_kind;
    h2ps2_pkg::t_code       r_s2_code;
    h2ps2_pkg::t_len        r_s2_len;
    h2ps2_pkg::t_idx        r_idx, n_idx;

    // output register
    logic                   r_out_vld;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    logic out_free, s2_emit, s2_last, s2_load, s1_take, in_acc;

    assign s1_len   = h2ps2_pkg::seq_len(r_s1_kind, r_s1_code);
    assign out_free = !r_out_vld || m_axis_tready;
    assign s2_emit  = r_s2_vld && out_free;
    assign s2_last  = ({1'b0, r_idx} == (r_s2_len - 4'd1));
    assign s2_load  = r_s1_vld && (s1_len != 4'd0) && (!r_s2_vld || (s2_emit && s2_last));
    assign s1_take  = r_s1_vld && ((s1_len == 4'd0) || s2_load);
    assign s_axis_tready = !r_s1_vld || s1_take;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_s2_vld = r_s2_vld;
        n_idx    = r_idx;
        if (s2_emit) begin
            n_idx = r_idx + 3'd1;
            if (s2_last) n_s2_vld = 1'b0;
        end
        if (s2_load) begin
            n_s2_vld = 1'b1;
            n_idx    = 3'd0;
        end
    end

    // code rom, registered read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_code <= h2ps2_pkg::set2_of_usage(s_axis_tdata);
            r_s1_kind <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_idx     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_take) begin
                r_s1_vld <= 1'b0;
            end
            r_s2_vld <= n_s2_vld;
            r_idx    <= n_idx;
            if (s2_emit) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_kind <= r_s1_kind;
            r_s2_code <= r_s1_code;
            r_s2_len  <= s1_len;
        end
        if (s2_emit) begin
            r_out_byte <= h2ps2_pkg::seq_byte(r_s2_kind, r_s2_code, r_idx);
            r_out_last <= s2_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// usb hid key events in, ps/2 set 2 scan code bytes out: a directed set of
// keys and special sequences, then random key events, with bursty input,
// a stalling receiver and one long receiver hold-off; every output beat is
// checked against a local prediction of the byte sequence
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [2:0] {
        KEY_UNMAPPED, KEY_PLAIN, KEY_EXTENDED, KEY_PRINT, KEY_PAUSE
    } t_key_class;

    typedef struct packed {
        t_key_class cls;
        logic [7:0] code;
    } t_key_entry;

    typedef struct packed {
        logic       kind;
        logic [7:0] usage;
    } t_key_event;

    typedef struct packed {
        logic [7:0] scan;
        logic       last;
    } t_scan_beat;

    localparam int NUM_KEY_EVENTS = 130;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = 8'h00;   // hid_usage[7:0]
    logic       s_axis_tuser   = 1'b0;    // kind
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;             // scan_byte[7:0]
    logic       m_axis_tlast;

    t_key_event pending_events[$];
    t_scan_beat expected_bytes[$];

    int  total_events;
    int  events_taken    = 0;
    int  bytes_checked   = 0;
    int  silent_events   = 0;
    int  special_events  = 0;
    int  error_count     = 0;
    logic in_beat_taken  = 1'b0;
    logic rx_hold        = 1'b0;

    hid_to_ps2_scancode_emitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_key_entry lookup_key(input logic [7:0] usage);
        t_key_entry e;
        e.cls  = KEY_PLAIN;
        e.code = 8'h00;
        case (usage)
            8'h04: e.code = 8'h1C; 8'h05: e.code = 8'h32; 8'h06: e.code = 8'h21;
            8'h07: e.code = 8'h23; 8'h08: e.code = 8'h24; 8'h09: e.code = 8'h2B;
            8'h0A: e.code = 8'h34; 8'h0B: e.code = 8'h33; 8'h0C: e.code = 8'h43;
            8'h0D: e.code = 8'h3B; 8'h0E: e.code = 8'h42; 8'h0F: e.code = 8'h4B;
            8'h10: e.code = 8'h3A; 8'h11: e.code = 8'h31; 8'h12: e.code = 8'h44;
            8'h13: e.code = 8'h4D; 8'h14: e.code = 8'h15; 8'h15: e.code = 8'h2D;
            8'h16: e.code = 8'h1B; 8'h17: e.code = 8'h2C; 8'h18: e.code = 8'h3C;
            8'h19: e.code = 8'h2A; 8'h1A: e.code = 8'h1D; 8'h1B: e.code = 8'h22;
            8'h1C: e.code = 8'h35; 8'h1D: e.code = 8'h1A; 8'h1E: e.code = 8'h16;
            8'h1F: e.code = 8'h1E; 8'h20: e.code = 8'h26; 8'h21: e.code = 8'h25;
            8'h22: e.code = 8'h2E; 8'h23: e.code = 8'h36; 8'h24: e.code = 8'h3D;
            8'h25: e.code = 8'h3E; 8'h26: e.code = 8'h46; 8'h27: e.code = 8'h45;
            8'h28: e.code = 8'h5A; 8'h29: e.code = 8'h76; 8'h2A: e.code = 8'h66;
            8'h2B: e.code = 8'h0D; 8'h2C: e.code = 8'h29; 8'h2D: e.code = 8'h4E;
            8'h2E: e.code = 8'h55; 8'h2F: e.code = 8'h54; 8'h30: e.code = 8'h5B;
            8'h31: e.code = 8'h5D; 8'h33: e.code = 8'h4C; 8'h34: e.code = 8'h52;
            8'h35: e.code = 8'h0E; 8'h36: e.code = 8'h41; 8'h37: e.code = 8'h49;
            8'h38: e.code = 8'h4A; 8'h39: e.code = 8'h58; 8'h3A: e.code = 8'h05;
            8'h3B: e.code = 8'h06; 8'h3C: e.code = 8'h04; 8'h3D: e.code = 8'h0C;
            8'h3E: e.code = 8'h03; 8'h3F: e.code = 8'h0B; 8'h40: e.code = 8'h83;
            8'h41: e.code = 8'h0A; 8'h42: e.code = 8'h01; 8'h43: e.code = 8'h09;
            8'h44: e.code = 8'h78; 8'h45: e.code = 8'h07; 8'h47: e.code = 8'h7E;
            8'h53: e.code = 8'h77; 8'h55: e.code = 8'h7C; 8'h56: e.code = 8'h7B;
            8'h57: e.code = 8'h79; 8'h59: e.code = 8'h69; 8'h5A: e.code = 8'h72;
            8'h5B: e.code = 8'h7A; 8'h5C: e.code = 8'h6B; 8'h5D: e.code = 8'h73;
            8'h5E: e.code = 8'h74; 8'h5F: e.code = 8'h6C; 8'h60: e.code = 8'h75;
            8'h61: e.code = 8'h7D; 8'h62: e.code = 8'h70; 8'h63: e.code = 8'h71;
            8'h64: e.code = 8'h61;
            8'h46: e.cls = KEY_PRINT;
            8'h48: e.cls = KEY_PAUSE;
            8'h49: e = '{KEY_EXTENDED, 8'h70}; 8'h4A: e = '{KEY_EXTENDED, 8'h6C};
            8'h4B: e = '{KEY_EXTENDED, 8'h7D}; 8'h4C: e = '{KEY_EXTENDED, 8'h71};
            8'h4D: e = '{KEY_EXTENDED, 8'h69}; 8'h4E: e = '{KEY_EXTENDED, 8'h7A};
            8'h4F: e = '{KEY_EXTENDED, 8'h74}; 8'h50: e = '{KEY_EXTENDED, 8'h6B};
            8'h51: e = '{KEY_EXTENDED, 8'h72}; 8'h52: e = '{KEY_EXTENDED, 8'h75};
            8'h54: e = '{KEY_EXTENDED, 8'h4A}; 8'h58: e = '{KEY_EXTENDED, 8'h5A};
            8'h65: e = '{KEY_EXTENDED, 8'h2F};
            default: e.cls = KEY_UNMAPPED;
        endcase
        return e;
    endfunction

    // scan bytes of one key event, byte 0 goes out first
    function automatic int build_sequence(input logic kind, input logic [7:0] usage,
                                          output logic [7:0][7:0] seq);
        t_key_entry e;
        int         n;
        e   = lookup_key(usage);
        n   = 0;
        seq = '0;
        case (e.cls)
            KEY_UNMAPPED: n = 0;
            KEY_PRINT: begin
                if (kind == h2ps2_pkg::KIND_BREAK) begin
                    seq[0] = h2ps2_pkg::BYTE_EXT; seq[1] = h2ps2_pkg::BYTE_BREAK;
                    seq[2] = h2ps2_pkg::BYTE_7C;  seq[3] = h2ps2_pkg::BYTE_EXT;
                    seq[4] = h2ps2_pkg::BYTE_BREAK; seq[5] = h2ps2_pkg::BYTE_12;
                    n = 6;
                end else begin
                    seq[0] = h2ps2_pkg::BYTE_EXT; seq[1] = h2ps2_pkg::BYTE_12;
                    seq[2] = h2ps2_pkg::BYTE_EXT; seq[3] = h2ps2_pkg::BYTE_7C;
                    n = 4;
                end
            end
            KEY_PAUSE: begin
                if (kind == h2ps2_pkg::KIND_MAKE) begin
                    seq[0] = h2ps2_pkg::BYTE_E1;    seq[1] = h2ps2_pkg::BYTE_14;
                    seq[2] = h2ps2_pkg::BYTE_77;    seq[3] = h2ps2_pkg::BYTE_E1;
                    seq[4] = h2ps2_pkg::BYTE_BREAK; seq[5] = h2ps2_pkg::BYTE_14;
                    seq[6] = h2ps2_pkg::BYTE_BREAK; seq[7] = h2ps2_pkg::BYTE_77;
                    n = 8;
                end
            end
            default: begin
                if (e.cls == KEY_EXTENDED) begin
                    seq[n] = h2ps2_pkg::BYTE_EXT;
                    n = n + 1;
                end
                if (kind == h2ps2_pkg::KIND_BREAK) begin
                    seq[n] = h2ps2_pkg::BYTE_BREAK;
                    n = n + 1;
                end
                seq[n] = e.code;
                n = n + 1;
            end
        endcase
        return n;
    endfunction

    task automatic predict_scan_bytes(input logic kind, input logic [7:0] usage);
        logic [7:0][7:0] seq;
        int              n;
        t_key_entry      e;
        n = build_sequence(kind, usage, seq);
        e = lookup_key(usage);
        if (n == 0) silent_events++;
        if (e.cls == KEY_PRINT || e.cls == KEY_PAUSE) special_events++;
        for (int i = 0; i < n; i++) begin
            expected_bytes.push_back('{seq[i], i == n - 1});
        end
    endtask

    // sender: bursts of beats, most of them separated by idle gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_key_event ev;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                ev = pending_events.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= ev.usage;
                s_axis_tuser  <= ev.kind;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: the stall pattern steps through always-ready, random, periodic and mostly-stalled phases
    logic [9:0] rx_cycle = '0;

    always @(negedge i_clk) begin
        logic ready_now;
        rx_cycle = rx_cycle + 1'b1;
        case (rx_cycle[7:6])
            2'd0:    ready_now = 1'b1;
            2'd1:    ready_now = 1'($urandom_range(0, 1));
            2'd2:    ready_now = (rx_cycle[1:0] != 2'd0);
            default: ready_now = ($urandom_range(0, 3) == 0);
        endcase
        m_axis_tready <= i_rst_n && !rx_hold && ready_now;
    end

    initial begin
        wait (events_taken >= 40);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (150) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_scan_beat want;
        in_beat_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_scan_bytes(s_axis_tuser, s_axis_tdata);
                events_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("error: unexpected beat %h last %b", m_axis_tdata,
                                 m_axis_tlast);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.scan || m_axis_tlast !== want.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("error at byte %0d: expected %h last %b, got %h last %b",
                                     bytes_checked, want.scan, want.last, m_axis_tdata,
                                     m_axis_tlast);
                    end
                end
                bytes_checked++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d bytes outstanding", expected_bytes.size());
        $display("hid_to_ps2_scancode_emitter: mismatch");
        $finish;
    end

    initial begin
        logic [7:0]      usage;
        logic            kind;
        int              pick;

        // plain, extended, print screen and pause keys, unmapped and modifier usages
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h04});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h04});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h1D});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h4F});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h4F});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h65});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h46});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h46});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h48});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h48});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h40});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h64});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h63});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h00});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h03});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h32});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h66});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'hFF});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'hFF});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'hE0});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'hE7});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h39});
        pending_events.push_back('{h2ps2_pkg::KIND_BREAK, 8'h53});
        pending_events.push_back('{h2ps2_pkg::KIND_MAKE,  8'h2C});

        while (pending_events.size() < NUM_KEY_EVENTS) begin
            pick = $urandom_range(0, 99);
            kind = 1'($urandom_range(0, 1));
            if (pick < 10) begin
                usage = 8'($urandom_range(0, 255));
            end else if (pick < 25) begin
                case ($urandom_range(0, 3))
                    0:       usage = 8'h46;
                    1:       usage = 8'h48;
                    2:       usage = 8'($urandom_range(8'h49, 8'h52));
                    default: usage = 8'h65;
                endcase
            end else begin
                usage = 8'($urandom_range(8'h04, 8'h65));
            end
            pending_events.push_back('{kind, usage});
        end
        total_events = pending_events.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (events_taken == total_events);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_bytes.size() != 0) error_count++;

        $display("covered %0d key events (%0d print screen or pause, %0d silent)",
                 events_taken, special_events, silent_events);
        $display("checked %0d scan bytes, %0d errors", bytes_checked, error_count);
        if (error_count == 0) begin
            $display("hid_to_ps2_scancode_emitter: match");
        end else begin
            $display("hid_to_ps2_scancode_emitter: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/h2ps2_pkg.sv
hw/rtl/hid_to_ps2_scancode_emitter.sv
bench/testbench.sv
